// ===== sv/spc_pkg.sv =====
// spc_pkg: shared types and fixed field widths for subsequence_product_count.
// No dependencies; imported by spc_div and subsequence_product_count.
`default_nettype none

package spc_pkg;

	localparam int VALUE_W = 16;
	localparam int BOUND_W = 10;
	localparam int OUT_W   = 32;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_WALK,
		ST_DRAIN,
		ST_FINISH,
		ST_OUTPUT
	} state_t;

endpackage

`default_nettype wire

// ===== sv/spc_table.sv =====
// spc_table: count table, one write port and two registered read ports.
// Depends on nothing but its parameters.
`default_nettype none

module spc_table #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int CW    = 32
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [CW-1:0] wdata,
	input  wire logic [AW-1:0] raddr_a,
	input  wire logic [AW-1:0] raddr_b,
	output logic      [CW-1:0] rdata_a,
	output logic      [CW-1:0] rdata_b
);

	logic [CW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

`default_nettype wire

// ===== sv/spc_div.sv =====
// spc_div: restoring divider, one quotient bit per cycle.
// Uses spc_pkg for the divisor width.
`default_nettype none

module spc_div #(
	parameter int QW = 10
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        go,
	input  wire logic [QW-1:0]               dividend,
	input  wire logic [spc_pkg::VALUE_W-1:0] divisor,
	output logic                             done,
	output logic      [QW-1:0]               quotient,
	output logic      [spc_pkg::VALUE_W-1:0] remainder
);

	import spc_pkg::*;

	localparam int CNW = $clog2(QW + 1);

	logic              run_q;
	logic [CNW-1:0]    cnt_q;
	logic [QW-1:0]     dvd_q;
	logic [QW-1:0]     quo_q;
	logic [VALUE_W-1:0] rem_q;
	logic [VALUE_W:0]  trial;
	logic              fits;

	assign trial = {rem_q, dvd_q[QW-1]};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (go) begin
			run_q <= 1'b1;
			cnt_q <= CNW'(QW);
		end else if (run_q) begin
			if (cnt_q == '0) begin
				run_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			dvd_q <= dividend;
			quo_q <= '0;
			rem_q <= '0;
		end else if (run_q && cnt_q != '0) begin
			dvd_q <= QW'({dvd_q, 1'b0});
			quo_q <= QW'({quo_q, fits});
			rem_q <= fits ? VALUE_W'(trial - {1'b0, divisor}) : VALUE_W'(trial);
		end
	end

	assign done      = run_q && cnt_q == '0;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

// ===== sv/subsequence_product_count.sv =====
// subsequence_product_count: top level, sequencer and table update datapath.
// Depends on spc_pkg, spc_div and spc_table.
//
// channel  | signals                      | transfer
// config   | cfg_we, cfg_wdata            | cfg_we high at a rising edge
// element  | start, busy, value, last     | start high and busy low
// result   | done, count, saturated       | done high for one cycle
//
// Element: the divider forms bound/value, then the walk steps down one entry
// at a time from the bound to value, then the drain and finish states; the single
// write port sets the walk rate. Skipped elements (value zero or above bound) go to finish.
// After last: an emit state, then a clear of entries 0..highest
// bound used in the sequence, one per cycle. After reset the clear covers all
// MAX_BOUND+1 entries. The receiver cannot stall; done is a single pulse.
`default_nettype none

module subsequence_product_count #(
	parameter int MAX_BOUND  = 1023,
	parameter int COUNT_BITS = 32
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [spc_pkg::BOUND_W-1:0] cfg_wdata,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [spc_pkg::VALUE_W-1:0] value,
	input  wire logic                        last,
	output logic                             done,
	output logic      [spc_pkg::OUT_W-1:0]   count,
	output logic                             saturated
);

	import spc_pkg::*;

	localparam int AW = $clog2(MAX_BOUND + 1);
	localparam int EW = (AW > BOUND_W) ? AW : BOUND_W;
	localparam int CW = COUNT_BITS;
	localparam logic [AW-1:0] MAXB = AW'(MAX_BOUND);

	state_t state_q, state_d;

	logic [BOUND_W-1:0] bound_q;
	logic [EW-1:0]      bk_ext;
	logic [AW-1:0]      b_eff;

	logic [VALUE_W-1:0] a_q;
	logic               last_q;
	logic [AW-1:0]      b_q;
	logic [AW-1:0]      p_q;
	logic [AW-1:0]      q_q;
	logic [VALUE_W-1:0] r_q;
	logic [AW-1:0]      hi_q;
	logic [AW-1:0]      clr_q;
	logic               sat_q;

	logic               valid_s1;
	logic [AW-1:0]      p_s1;

	logic               accept;
	logic               skip;
	logic               walk_end;
	logic               clr_end;

	logic               div_go;
	logic               div_kick_q;
	logic               div_done;
	logic [AW-1:0]      div_quo;
	logic [VALUE_W-1:0] div_rem;

	logic               we;
	logic [AW-1:0]      waddr;
	logic [CW-1:0]      wdata;
	logic [AW-1:0]      raddr_a;
	logic [AW-1:0]      raddr_b;
	logic [CW-1:0]      rdata_a;
	logic [CW-1:0]      rdata_b;
	logic [CW:0]        sum;
	logic               upd_sat;
	logic [CW-1:0]      upd;

	logic               done_q;
	logic [OUT_W-1:0]   count_q;
	logic               saturated_q;

	// bound clamp
	assign bk_ext = EW'(bound_q);
	assign b_eff  = (bk_ext > EW'(MAX_BOUND)) ? MAXB : AW'(bk_ext);

	assign accept   = start && !busy;
	assign skip     = (value == '0) || (value > VALUE_W'(b_eff));
	assign walk_end = p_q == AW'(a_q);
	assign clr_end  = clr_q == hi_q;

	assign sum     = {1'b0, rdata_a} + {1'b0, rdata_b} + (CW + 1)'(1);
	assign upd_sat = sum[CW];
	assign upd     = upd_sat ? {CW{1'b1}} : sum[CW-1:0];

	spc_div #(
		.QW(AW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (b_q),
		.divisor  (a_q),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	spc_table #(
		.DEPTH(MAX_BOUND + 1),
		.AW   (AW),
		.CW   (CW)
	) u_table (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(rdata_a),
		.rdata_b(rdata_b)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_end) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) state_d = skip ? ST_FINISH : ST_DIV;
			end
			ST_DIV: begin
				if (div_done) state_d = ST_WALK;
			end
			ST_WALK: begin
				if (walk_end) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				state_d = last_q ? ST_OUTPUT : ST_IDLE;
			end
			ST_OUTPUT: begin
				state_d = ST_CLEAR;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy    = 1'b1;
		div_go  = 1'b0;
		raddr_a = p_q;
		raddr_b = q_q;
		we      = valid_s1;
		waddr   = p_s1;
		wdata   = upd;
		unique case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = '0;
			end
			ST_IDLE: begin
				busy = 1'b0;
			end
			ST_DIV: begin
				// divider starts the cycle after the element is latched
				div_go = div_kick_q;
			end
			ST_WALK, ST_DRAIN: begin
				busy = 1'b1;
			end
			ST_FINISH: begin
				raddr_a = b_q;
			end
			ST_OUTPUT: begin
				busy = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			bound_q  <= BOUND_W'(1);
			hi_q     <= MAXB;
			clr_q    <= '0;
			sat_q    <= 1'b0;
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= state_q == ST_WALK;
			done_q   <= state_q == ST_OUTPUT;
			if (cfg_we) begin
				bound_q <= cfg_wdata;
			end
			if (accept && !skip && b_eff > hi_q) begin
				hi_q <= b_eff;
			end
			if (valid_s1 && upd_sat) begin
				sat_q <= 1'b1;
			end
			if (state_q == ST_CLEAR) begin
				sat_q <= 1'b0;
				if (clr_end) begin
					clr_q <= '0;
					hi_q  <= '0;
				end else begin
					clr_q <= clr_q + 1'b1;
				end
			end
		end
	end

	// divider kick is registered off the accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_kick_q <= 1'b0;
		end else begin
			div_kick_q <= accept && !skip;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			a_q    <= value;
			last_q <= last;
			b_q    <= b_eff;
		end
		if (state_q == ST_DIV && div_done) begin
			p_q <= b_q;
			q_q <= div_quo;
			r_q <= div_rem;
		end else if (state_q == ST_WALK) begin
			p_q <= p_q - 1'b1;
			if (r_q == '0) begin
				q_q <= q_q - 1'b1;
				r_q <= a_q - 1'b1;
			end else begin
				r_q <= r_q - 1'b1;
			end
		end
		p_s1 <= p_q;
		if (state_q == ST_OUTPUT) begin
			count_q     <= OUT_W'(rdata_a);
			saturated_q <= sat_q;
		end
	end

	assign done      = done_q;
	assign count     = count_q;
	assign saturated = saturated_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_OUTPUT))
		else $error("result strobe without emit state");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> q_q != '0)
		else $error("walk reads entry zero as source");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> p_s1 <= hi_q)
		else $error("table write above tracked clear range");

	assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !valid_s1 && div_kick_q == 1'b0)
		else $error("element accepted while update in flight");

	assert property (@(posedge clk) disable iff (!arst_n)
		div_kick_q |-> state_q == ST_DIV)
		else $error("divider kicked outside divide state");

endmodule

`default_nettype wire
